[src/zero_preserving_vector_line_fir_defines.svh]
// Assertion macros shared by the RTL files of the vector line filter.
// Each macro takes a label, the clock, the active-low reset, an antecedent,
// a consequent and a message string.
`ifndef ZERO_PRESERVING_VECTOR_LINE_FIR_DEFINES_SVH
`define ZERO_PRESERVING_VECTOR_LINE_FIR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ZPVF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ZPVF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/zpvf_pkg.sv]
// ----------------------------------------------------------------------------
// zpvf_pkg
// Shared constants, register codes and types of the vector line filter.
// ----------------------------------------------------------------------------
package zpvf_pkg;

    // Configuration port.
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_WORD_0   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_WORD_1   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_WORD_2   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_WORD_3   = 3'd4;

    // Coefficient storage: four 64-bit words of four 16-bit slots each.
    localparam int KL_W           = 4;
    localparam int COEF_WORDS     = 4;
    localparam int COEF_WORD_IW   = 2;
    localparam int SLOTS_PER_WORD = 4;
    localparam int COEF_SLOT_W    = 16;
    // Slot 15 is never used as a tap.
    localparam int COEF_SLOTS     = 15;

    // At most this many results leave for one input transaction.
    localparam int MAX_RESULTS  = 8;
    localparam int RESULT_CNT_W = 3;

    localparam logic [KL_W-1:0]       KL_RESET          = 4'd1;
    localparam logic [CFG_DATA_W-1:0] COEF_WORD_0_RESET = 64'd16384;

    // Flags that travel with each filter job down the datapath.
    typedef struct packed {
        logic zero;
        logic last;
    } zpvf_tag_t;

endpackage

[src/zpvf_channels.sv]
// ----------------------------------------------------------------------------
// zpvf channels
// Valid/ready stream interfaces for input samples and filtered results.
// ----------------------------------------------------------------------------
interface zpvf_sample_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] vec_x;
    logic signed [SAMPLE_BITS-1:0] vec_y;
    logic                          line_end;

    modport source (output valid, vec_x, vec_y, line_end, input ready);
    modport sink   (input valid, vec_x, vec_y, line_end, output ready);
endinterface

interface zpvf_result_if #(
    parameter int SAMPLE_BITS = 16
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_x;
    logic signed [SAMPLE_BITS-1:0] out_y;
    logic                          out_last;

    modport source (output valid, out_x, out_y, out_last, input ready);
    modport sink   (input valid, out_x, out_y, out_last, output ready);
endinterface

[src/zpvf_mac.sv]
// ----------------------------------------------------------------------------
// zpvf_mac
// Four-stage filter datapath: window alignment, tap products, partial sums,
// final sum with rounding and saturation into the result register.
// ----------------------------------------------------------------------------
module zpvf_mac
    import zpvf_pkg::*;
#(
    parameter int MAX_TAPS    = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16,
    parameter int LANES       = 15,
    parameter int OW          = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    output logic                          job_ready,
    input  zpvf_tag_t                     job_tag,
    input  logic [OW-1:0]                 job_offset,
    input  logic signed [SAMPLE_BITS-1:0] win_x [MAX_TAPS],
    input  logic signed [SAMPLE_BITS-1:0] win_y [MAX_TAPS],
    input  logic signed [COEF_BITS-1:0]   coef [LANES],
    zpvf_result_if.source                 result
);

    localparam int HALF_MAX = (MAX_TAPS - 1) / 2;
    localparam int WIDE_N   = MAX_TAPS + 2 * HALF_MAX;
    localparam int PRW      = SAMPLE_BITS + COEF_BITS;
    localparam int PSW      = PRW + 2;
    localparam int AW       = PRW + 4;
    localparam int NG       = (LANES + 3) / 4;
    localparam int CF       = COEF_BITS - 2;

    localparam logic signed [AW:0] BIAS = {{(AW + 1 - CF){1'b0}}, 1'b1, {(CF - 1){1'b0}}};
    localparam logic signed [AW:0] HI_V = {{(AW + 2 - SAMPLE_BITS){1'b0}},
                                           {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [AW:0] LO_V = ~HI_V;

    // Stage registers.
    logic                          a_valid_reg;
    logic signed [SAMPLE_BITS-1:0] a_x_reg [LANES];
    logic signed [SAMPLE_BITS-1:0] a_y_reg [LANES];
    zpvf_tag_t                     a_tag_reg;

    logic                          p_valid_reg;
    logic signed [PRW-1:0]         p_x_reg [LANES];
    logic signed [PRW-1:0]         p_y_reg [LANES];
    zpvf_tag_t                     p_tag_reg;

    logic                          s_valid_reg;
    logic signed [PSW-1:0]         s_x_reg [NG];
    logic signed [PSW-1:0]         s_y_reg [NG];
    zpvf_tag_t                     s_tag_reg;

    logic                          o_valid_reg;
    logic signed [SAMPLE_BITS-1:0] o_x_reg;
    logic signed [SAMPLE_BITS-1:0] o_y_reg;
    logic                          o_last_reg;

    logic a_ready, p_ready, s_ready, o_ready;

    logic [WIDE_N*SAMPLE_BITS-1:0] wide_x, wide_y;
    logic [WIDE_N*SAMPLE_BITS-1:0] shift_x, shift_y;
    logic signed [PSW-1:0]         part_x [NG];
    logic signed [PSW-1:0]         part_y [NG];
    logic signed [SAMPLE_BITS-1:0] fin_x, fin_y;

    // Each stage moves when it is empty or the next stage takes its content.
    assign o_ready   = !o_valid_reg || result.ready;
    assign s_ready   = !s_valid_reg || o_ready;
    assign p_ready   = !p_valid_reg || s_ready;
    assign a_ready   = !a_valid_reg || p_ready;
    assign job_ready = a_ready;

    // Barrel shift that places the first tap's sample in lane 0.
    always_comb
    begin
        wide_x = '0;
        wide_y = '0;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            wide_x[(i + HALF_MAX)*SAMPLE_BITS +: SAMPLE_BITS] = win_x[i];
            wide_y[(i + HALF_MAX)*SAMPLE_BITS +: SAMPLE_BITS] = win_y[i];
        end
        shift_x = wide_x;
        shift_y = wide_y;
        for (int b = 0; b < OW; b++)
        begin
            if (job_offset[b])
            begin
                shift_x = shift_x >> (SAMPLE_BITS << b);
                shift_y = shift_y >> (SAMPLE_BITS << b);
            end
        end
    end

    // Partial sums over groups of four lanes.
    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            part_x[g] = '0;
            part_y[g] = '0;
            for (int q = 0; q < 4; q++)
            begin
                if (g * 4 + q < LANES)
                begin
                    part_x[g] = part_x[g] + PSW'(p_x_reg[g*4 + q]);
                    part_y[g] = part_y[g] + PSW'(p_y_reg[g*4 + q]);
                end
            end
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] finish(
        input logic signed [PSW-1:0] parts [NG]
    );
        logic signed [AW:0] acc;
        logic signed [AW:0] shr;
        acc = '0;
        for (int g = 0; g < NG; g++)
        begin
            acc = acc + (AW + 1)'(parts[g]);
        end
        shr = (acc + BIAS) >>> CF;
        if (shr > HI_V)
        begin
            shr = HI_V;
        end
        else if (shr < LO_V)
        begin
            shr = LO_V;
        end
        return shr[SAMPLE_BITS-1:0];
    endfunction

    assign fin_x = finish(s_x_reg);
    assign fin_y = finish(s_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= job_valid;
            end
            if (p_ready)
            begin
                p_valid_reg <= a_valid_reg;
            end
            if (s_ready)
            begin
                s_valid_reg <= p_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && job_valid)
        begin
            for (int m = 0; m < LANES; m++)
            begin
                a_x_reg[m] <= shift_x[m*SAMPLE_BITS +: SAMPLE_BITS];
                a_y_reg[m] <= shift_y[m*SAMPLE_BITS +: SAMPLE_BITS];
            end
            a_tag_reg <= job_tag;
        end
        if (p_ready && a_valid_reg)
        begin
            for (int m = 0; m < LANES; m++)
            begin
                p_x_reg[m] <= a_x_reg[m] * coef[m];
                p_y_reg[m] <= a_y_reg[m] * coef[m];
            end
            p_tag_reg <= a_tag_reg;
        end
        if (s_ready && p_valid_reg)
        begin
            s_x_reg   <= part_x;
            s_y_reg   <= part_y;
            s_tag_reg <= p_tag_reg;
        end
        if (o_ready && s_valid_reg)
        begin
            o_x_reg    <= s_tag_reg.zero ? '0 : fin_x;
            o_y_reg    <= s_tag_reg.zero ? '0 : fin_y;
            o_last_reg <= s_tag_reg.last;
        end
    end

    assign result.valid    = o_valid_reg;
    assign result.out_x    = o_x_reg;
    assign result.out_y    = o_y_reg;
    assign result.out_last = o_last_reg;

endmodule

[src/zero_preserving_vector_line_fir.sv]
// ----------------------------------------------------------------------------
// zero_preserving_vector_line_fir
// Centered odd-length FIR over a line of (x, y) samples, zero padded past
// both line ends, with zero results wherever the center sample is zero.
// ----------------------------------------------------------------------------
// Usage: samples enter on the sample channel, one transaction per sample in
// line order, with line_end set on the last sample of each line. Filtered
// samples leave on the result channel in the same order; out_last marks the
// final result of each line. Registers are written through cfg_we,
// cfg_index and cfg_data while no line is in progress.
// Throughput: one sample per cycle while the result channel is ready. A
// transaction with line_end also flushes the results still owed for the line,
// up to eight in all; they leave one per cycle from the same window when not
// stalled, and the sample channel holds ready low until the last is in the job register.
// Path: a result passes through the job register, which loads on the edge that
// takes the transaction completing its window, then the alignment, product,
// partial sum and output registers.
// Reset: registers return to their defaults, the window reads as empty and
// every pipeline stage is emptied.
// Stalls: when the result channel is not ready the pipeline holds its data;
// samples are still taken until every stage between is occupied.
// ----------------------------------------------------------------------------
`include "zero_preserving_vector_line_fir_defines.svh"

module zero_preserving_vector_line_fir
    import zpvf_pkg::*;
#(
    parameter int MAX_TAPS    = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    zpvf_sample_if.sink            sample,
    zpvf_result_if.source          result
);

    // Largest half kernel that the window supports.
    localparam int HALF_MAX = (MAX_TAPS - 1) / 2;
    // Largest odd kernel length that fits the window.
    localparam int LIM      = (MAX_TAPS % 2 == 1) ? MAX_TAPS : MAX_TAPS - 1;
    // Number of multiplier lanes; the registers hold at most fifteen taps.
    localparam int LANES    = (MAX_TAPS < COEF_SLOTS) ? MAX_TAPS : COEF_SLOTS;
    // Width of a center index, of the pending count plus one, of the
    // alignment offset and of an index into the window.
    localparam int CW       = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
    localparam int PW       = $clog2(HALF_MAX + 2);
    localparam int OW       = (HALF_MAX > 0) ? $clog2(2 * HALF_MAX + 1) : 1;
    localparam int IW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    // Configuration registers.
    logic [KL_W-1:0]       kl_reg;
    logic [CFG_DATA_W-1:0] coef_word_reg [COEF_WORDS];

    // Sample window, newest sample at index 0.
    logic signed [SAMPLE_BITS-1:0] win_x_reg [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] win_y_reg [MAX_TAPS];

    // Line control. The window is only logically cleared: clr_reg makes the
    // next transaction shift in zeros behind the new sample.
    logic                    clr_reg,       clr_next;
    logic [CW-1:0]           pend_reg,      pend_next;
    logic                    job_valid_reg, job_valid_next;
    logic [CW-1:0]           job_c_reg,     job_c_next;
    logic                    job_last_reg,  job_last_next;
    logic [RESULT_CNT_W-1:0] job_rem_reg,   job_rem_next;

    logic [KL_W-1:0]         k_odd;
    logic [KL_W-1:0]         k_use;
    logic [KL_W-2:0]         half;
    logic [PW-1:0]           p1;
    logic                    emit;
    logic [RESULT_CNT_W-1:0] rem_fill;
    logic                    accept;
    logic                    mac_ready;
    logic                    job_taken;
    logic [MAX_TAPS-1:0]     nz_vec;
    logic [7:0]              off_wide;
    logic [OW-1:0]           job_offset;
    zpvf_tag_t               job_tag;

    logic signed [COEF_BITS-1:0]       coef_lane [LANES];
    logic [CFG_DATA_W+COEF_BITS-1:0]   coef_ext  [COEF_WORDS];

    // Kernel length in use: forced odd, clipped to the window.
    assign k_odd = kl_reg | KL_W'(1);
    assign k_use = (int'(k_odd) > LIM) ? KL_W'(LIM) : k_odd;
    assign half  = k_use[KL_W-1:1];

    // The pending count never exceeds HALF_MAX after a step, so the arriving
    // sample always raises it by one.
    assign p1       = PW'(pend_reg) + PW'(1);
    assign emit     = 8'(p1) > 8'(half);
    assign rem_fill = (int'(p1) > MAX_RESULTS) ? RESULT_CNT_W'(MAX_RESULTS - 1)
                                               : RESULT_CNT_W'(p1 - PW'(1));

    // New samples are held off while a flush is still draining or while the
    // job register cannot pass its job on.
    assign job_taken    = job_valid_reg && mac_ready;
    assign sample.ready = (job_rem_reg == '0) && (!job_valid_reg || mac_ready);
    assign accept       = sample.valid && sample.ready;

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kl_reg           <= KL_RESET;
            coef_word_reg[0] <= COEF_WORD_0_RESET;
            for (int w = 1; w < COEF_WORDS; w++)
            begin
                coef_word_reg[w] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                REG_KERNEL_LENGTH:
                begin
                    kl_reg <= cfg_data[KL_W-1:0];
                end
                REG_COEF_WORD_0, REG_COEF_WORD_1, REG_COEF_WORD_2, REG_COEF_WORD_3:
                begin
                    coef_word_reg[COEF_WORD_IW'(cfg_index - REG_COEF_WORD_0)] <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Tap m takes COEF_BITS bits from the base of its slot, reading zeros past the
    // top of its word. Taps beyond the kernel length contribute nothing.
    always_comb
    begin
        for (int w = 0; w < COEF_WORDS; w++)
        begin
            coef_ext[w] = {{COEF_BITS{1'b0}}, coef_word_reg[w]};
        end
        for (int m = 0; m < LANES; m++)
        begin
            if (m < int'(k_use))
            begin
                coef_lane[m] = coef_ext[m / SLOTS_PER_WORD]
                                       [(m % SLOTS_PER_WORD)*COEF_SLOT_W +: COEF_BITS];
            end
            else
            begin
                coef_lane[m] = '0;
            end
        end
    end

    // Window shift register, advanced by each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_x_reg[0] <= sample.vec_x;
            win_y_reg[0] <= sample.vec_y;
            for (int i = 1; i < MAX_TAPS; i++)
            begin
                win_x_reg[i] <= clr_reg ? '0 : win_x_reg[i-1];
                win_y_reg[i] <= clr_reg ? '0 : win_y_reg[i-1];
            end
        end
    end

    // Job scheduling. A result is centered on the oldest pending sample. At
    // a line end every pending sample gets its result, centers counting down
    // from the oldest toward the newest, and the final one carries out_last.
    always_comb
    begin
        clr_next       = clr_reg;
        pend_next      = pend_reg;
        job_valid_next = job_valid_reg;
        job_c_next     = job_c_reg;
        job_last_next  = job_last_reg;
        job_rem_next   = job_rem_reg;
        if (accept)
        begin
            clr_next = sample.line_end;
            if (sample.line_end)
            begin
                job_valid_next = 1'b1;
                job_c_next     = CW'(p1 - PW'(1));
                job_last_next  = (p1 == PW'(1));
                job_rem_next   = rem_fill;
                pend_next      = '0;
            end
            else if (emit)
            begin
                job_valid_next = 1'b1;
                job_c_next     = CW'(p1 - PW'(1));
                job_last_next  = 1'b0;
                job_rem_next   = '0;
                pend_next      = CW'(p1 - PW'(1));
            end
            else
            begin
                job_valid_next = 1'b0;
                pend_next      = CW'(p1);
            end
        end
        else if (job_taken)
        begin
            if (job_rem_reg != '0)
            begin
                job_c_next    = job_c_reg - CW'(1);
                job_rem_next  = job_rem_reg - RESULT_CNT_W'(1);
                job_last_next = (job_c_reg == CW'(1));
            end
            else
            begin
                job_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= 1'b1;
            pend_reg      <= '0;
            job_valid_reg <= 1'b0;
            job_c_reg     <= '0;
            job_last_reg  <= 1'b0;
            job_rem_reg   <= '0;
        end
        else
        begin
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            job_valid_reg <= job_valid_next;
            job_c_reg     <= job_c_next;
            job_last_reg  <= job_last_next;
            job_rem_reg   <= job_rem_next;
        end
    end

    // Zero test of the center sample, and the alignment offset that brings the
    // sample under the first tap into lane 0.
    always_comb
    begin
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            nz_vec[i] = (win_x_reg[i] != '0) || (win_y_reg[i] != '0);
        end
    end

    assign off_wide     = 8'(job_c_reg) + 8'(HALF_MAX) - 8'(half);
    assign job_offset   = off_wide[OW-1:0];
    assign job_tag.zero = !nz_vec[IW'(job_c_reg)];
    assign job_tag.last = job_last_reg;

    zpvf_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS),
        .LANES       (LANES),
        .OW          (OW)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid_reg),
        .job_ready  (mac_ready),
        .job_tag    (job_tag),
        .job_offset (job_offset),
        .win_x      (win_x_reg),
        .win_y      (win_y_reg),
        .coef       (coef_lane),
        .result     (result)
    );

    // A flush in progress always has a job on hand.
    `ZPVF_ASSERT_IMPL(a_drain_has_job, clk, rst_n, job_rem_reg != '0, job_valid_reg,
        "flush counter set without a pending job")
    // The pending count stays within half the window.
    `ZPVF_ASSERT_IMPL(a_pend_bound, clk, rst_n, 1'b1, int'(pend_reg) <= HALF_MAX,
        "pending count beyond half the window")
    // A job that the datapath refuses is held unchanged.
    `ZPVF_ASSERT_NEXT(a_job_held, clk, rst_n, job_valid_reg && !mac_ready,
        job_valid_reg && $stable(job_c_reg) && $stable(job_rem_reg) && $stable(job_last_reg),
        "stalled job changed")
    // A line end leaves nothing pending and clears the window for the next line.
    `ZPVF_ASSERT_NEXT(a_line_end_reset, clk, rst_n, accept && sample.line_end,
        clr_reg && (pend_reg == '0) && job_valid_reg,
        "line end did not restart the line state")

endmodule
